// ===== rtl/core/ledscan_pkg.sv =====
package ledscan_pkg;

  localparam logic [2:0] OP_TICK        = 3'd0;
  localparam logic [2:0] OP_WRITE_BYTE  = 3'd1;
  localparam logic [2:0] OP_WRITE_LINE  = 3'd2;
  localparam logic [2:0] OP_WRITE_PIXEL = 3'd3;
  localparam logic [2:0] OP_READ_BYTE   = 3'd4;
  localparam logic [2:0] OP_SELECT      = 3'd5;
  localparam logic [2:0] OP_NEXT        = 3'd6;

  localparam logic KIND_SCAN = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [4:0] BYTES_PER_FRAME = 5'd24;
  localparam logic [2:0] LAST_LINE       = 3'd7;
  localparam logic [4:0] BRIGHT_RESET    = 5'd16;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] frame;
    logic [4:0] byte_index;
    logic [2:0] column;
    logic [2:0] bit_pos;
    logic [7:0] red_value;
    logic [7:0] green_value;
    logic [7:0] blue_value;
    logic [7:0] write_data;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] row_index;
    logic [7:0] blue_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] read_data;
    logic [3:0] frame_count;
    logic [2:0] shown_frame;
  } result_t;

  typedef struct packed {
    logic latch;
    logic clr;
    logic rd;
    logic exe;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } status_t;

  // line of a byte index: (bi * 11) >> 5 equals bi / 3 below 24
  function automatic logic [2:0] line_of(input logic [4:0] bi);
    logic [8:0] p;
    p = 9'(bi) * 9'd11;
    return p[7:5];
  endfunction

  // color byte within a line: 0 red, 1 green, 2 blue
  function automatic logic [1:0] sub_of(input logic [4:0] bi);
    logic [4:0] l3;
    logic [4:0] r;
    l3 = 5'(line_of(bi)) * 5'd3;
    r  = bi - l3;
    return r[1:0];
  endfunction

endpackage

// ===== rtl/core/ledscan_ctrl.sv =====
module ledscan_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  ledscan_pkg::status_t sts_i,
  output ledscan_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_EXEC  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_READ;
      ST_CLEAR: if (sts_i.clr_last) state_d = ST_IDLE;
      ST_READ:  state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.latch = accept;
    cmd_o.clr   = (state_q == ST_CLEAR);
    cmd_o.rd    = (state_q == ST_READ);
    cmd_o.exe   = (state_q == ST_EXEC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/ledscan_dp.sv =====
module ledscan_dp #(
  parameter int FRAMES = 8,
  parameter int LEVELS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ledscan_pkg::item_t   item_i,
  input  logic                 cfg_we_i,
  input  logic [4:0]           cfg_wdata_i,
  input  ledscan_pkg::cmd_t    cmd_i,
  output ledscan_pkg::status_t sts_o,
  output logic                 out_valid_o,
  output ledscan_pkg::result_t result_o
);

  localparam int DEPTH = FRAMES * 8;
  localparam int AW    = $clog2(DEPTH);
  localparam int FR_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FU_W  = $clog2(FRAMES + 1);
  localparam int LV_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CW    = (LV_W > 5) ? LV_W : 5;

  logic [23:0]       mem_q [DEPTH];
  logic [2:0][7:0]   rdata_q;
  ledscan_pkg::item_t req_q;
  logic [AW-1:0]     clr_q;
  logic [4:0]        bright_q;
  logic [FU_W-1:0]   fu_q, fu_d;
  logic [FR_W-1:0]   disp_q, disp_d;
  logic [2:0]        line_q, line_d;
  logic [LV_W-1:0]   level_q, level_d;
  logic              out_valid_q;
  ledscan_pkg::result_t result_q, result_d;

  logic [2:0]      line_sel;
  logic [FR_W-1:0] frame_sel;
  logic [AW-1:0]   addr;
  logic [1:0]      sub;
  logic            f_ok, bi_ok, lit, ex_we, res_v;
  logic [2:0][7:0] wline;
  logic [7:0]      mask, sel_byte, nd, fu_ext, disp_ext;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [23:0]     wdata;

  assign sts_o.clr_last = (clr_q == AW'(DEPTH - 1));

  // line address for the latched request
  always_comb begin
    if (req_q.op == ledscan_pkg::OP_TICK) begin
      line_sel  = line_q;
      frame_sel = disp_q;
    end else begin
      if (req_q.op == ledscan_pkg::OP_WRITE_BYTE || req_q.op == ledscan_pkg::OP_READ_BYTE) begin
        line_sel = ledscan_pkg::line_of(req_q.byte_index);
      end else begin
        line_sel = req_q.column;
      end
      frame_sel = req_q.frame[FR_W-1:0];
    end
    addr = AW'({frame_sel, line_sel});
  end

  assign sub   = ledscan_pkg::sub_of(req_q.byte_index);
  assign f_ok  = (req_q.frame < 8'(FRAMES));
  assign bi_ok = (req_q.byte_index < ledscan_pkg::BYTES_PER_FRAME);
  assign lit   = (CW'(level_q) < CW'(bright_q));
  assign mask  = 8'd1 << req_q.bit_pos;
  assign nd    = 8'(disp_q) + 8'd1;
  assign fu_ext   = 8'(fu_q);
  assign disp_ext = 8'(disp_q);

  always_comb begin
    case (sub)
      2'd0:    sel_byte = rdata_q[0];
      2'd1:    sel_byte = rdata_q[1];
      2'd2:    sel_byte = rdata_q[2];
      default: sel_byte = 8'd0;
    endcase
  end

  always_comb begin
    wline    = rdata_q;
    ex_we    = 1'b0;
    res_v    = 1'b0;
    fu_d     = fu_q;
    disp_d   = disp_q;
    line_d   = line_q;
    level_d  = level_q;
    result_d = '0;
    result_d.frame_count = fu_ext[3:0];
    result_d.shown_frame = disp_ext[2:0];
    case (req_q.op)
      ledscan_pkg::OP_TICK: begin
        res_v              = 1'b1;
        result_d.kind      = ledscan_pkg::KIND_SCAN;
        result_d.row_index = line_q;
        result_d.red_out   = lit ? rdata_q[0] : 8'd0;
        result_d.green_out = lit ? rdata_q[1] : 8'd0;
        result_d.blue_out  = lit ? rdata_q[2] : 8'd0;
        if (line_q == ledscan_pkg::LAST_LINE) begin
          line_d  = 3'd0;
          level_d = (level_q == LV_W'(LEVELS - 1)) ? '0 : level_q + 1'b1;
        end else begin
          line_d = line_q + 3'd1;
        end
      end
      ledscan_pkg::OP_WRITE_BYTE: begin
        case (sub)
          2'd0:    wline[0] = req_q.write_data;
          2'd1:    wline[1] = req_q.write_data;
          2'd2:    wline[2] = req_q.write_data;
          default: wline    = rdata_q;
        endcase
        ex_we = f_ok && bi_ok;
      end
      ledscan_pkg::OP_WRITE_LINE: begin
        wline = {req_q.blue_value, req_q.green_value, req_q.red_value};
        ex_we = f_ok;
      end
      ledscan_pkg::OP_WRITE_PIXEL: begin
        wline[0] = (req_q.red_value != 8'd0) ? (rdata_q[0] | mask) : (rdata_q[0] & ~mask);
        wline[1] = (req_q.green_value != 8'd0) ? (rdata_q[1] | mask) : (rdata_q[1] & ~mask);
        wline[2] = (req_q.blue_value != 8'd0) ? (rdata_q[2] | mask) : (rdata_q[2] & ~mask);
        ex_we    = f_ok;
      end
      ledscan_pkg::OP_READ_BYTE: begin
        res_v         = 1'b1;
        result_d.kind = ledscan_pkg::KIND_READ;
        if (f_ok && bi_ok && (req_q.frame < fu_ext)) begin
          result_d.read_data = sel_byte;
        end
      end
      ledscan_pkg::OP_SELECT: begin
        if (req_q.frame < fu_ext) disp_d = req_q.frame[FR_W-1:0];
      end
      ledscan_pkg::OP_NEXT: begin
        disp_d = (nd >= fu_ext) ? '0 : nd[FR_W-1:0];
      end
      default: begin
      end
    endcase
    // a write into a valid frame at or past the frame count grows the count to include that frame
    if ((req_q.op == ledscan_pkg::OP_WRITE_BYTE || req_q.op == ledscan_pkg::OP_WRITE_LINE ||
         req_q.op == ledscan_pkg::OP_WRITE_PIXEL) && f_ok && (req_q.frame >= fu_ext)) begin
      fu_d = FU_W'(req_q.frame) + 1'b1;
    end
  end

  assign we    = cmd_i.clr || (cmd_i.exe && ex_we);
  assign waddr = cmd_i.clr ? clr_q : addr;
  assign wdata = cmd_i.clr ? 24'd0 : wline;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= item_i;
    end
    if (cmd_i.exe) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      bright_q    <= ledscan_pkg::BRIGHT_RESET;
      fu_q        <= FU_W'(1);
      disp_q      <= '0;
      line_q      <= '0;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) bright_q <= cfg_wdata_i;
      out_valid_q <= cmd_i.exe && res_v;
      if (cmd_i.exe) begin
        fu_q    <= fu_d;
        disp_q  <= disp_d;
        line_q  <= line_d;
        level_q <= level_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

// ===== rtl/core/rgb_led_matrix_frame_scanner.sv =====
// frame store and row scanner for an 8x8 rgb led matrix
//
// requests arrive on item_i and are taken at a rising edge with start high
// and busy low. op selects a tick, a byte, line or pixel write, a byte read,
// a frame select or a step to the next frame. only ticks and byte reads give
// a result: result_o is valid for exactly one cycle while out_valid_o is high,
// and the receiver has no way to hold it off.
// each request is latched, then its 24-bit line is read from the frame
// store into a register, then the result is computed, written back and
// registered. the result shows in the cycle in which busy drops, so a
// new request is only taken once the last one is through.
// the brightness register is written through cfg_we_i / cfg_wdata_i and
// holds 16 after reset; the user must write it only while the block is
// idle, and the block itself leaves this unchecked.
// after reset the store is swept to zero, one line per cycle over all
// FRAMES * 8 lines; busy stays high until the sweep is done.
module rgb_led_matrix_frame_scanner #(
  parameter int FRAMES = 8,
  parameter int LEVELS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  ledscan_pkg::item_t   item_i,
  input  logic                 cfg_we_i,
  input  logic [4:0]           cfg_wdata_i,
  output logic                 out_valid_o,
  output ledscan_pkg::result_t result_o
);

  ledscan_pkg::cmd_t    cmd;
  ledscan_pkg::status_t sts;

  ledscan_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ledscan_dp #(
    .FRAMES (FRAMES),
    .LEVELS (LEVELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .result_o    (result_o)
  );

endmodule

// ===== rtl/core/ledscan_checker.sv =====
module ledscan_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid_o,
  input ledscan_pkg::result_t result_o
);

  // an accepted request keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // a result follows a busy cycle and never repeats in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($past(busy) ##1 !out_valid_o))
    else $error("result strobe out of sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_o.kind == ledscan_pkg::KIND_SCAN) |-> (result_o.read_data == 8'd0))
    else $error("scan result carries read data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_o.kind == ledscan_pkg::KIND_READ) |->
      (result_o.row_index == 3'd0 && result_o.red_out == 8'd0 &&
       result_o.green_out == 8'd0 && result_o.blue_out == 8'd0))
    else $error("read result carries scan data");

endmodule

bind rgb_led_matrix_frame_scanner ledscan_checker u_ledscan_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .out_valid_o (out_valid_o),
  .result_o    (result_o)
);
